// ----- rtl/uhps_pkg.sv -----
// ----------------------------------------------------------------------------
// URL host/port/path splitter - shared package
// Types, codes and constant tables used by the step unit and the top level.
// ----------------------------------------------------------------------------
package uhps_pkg;

  // Parse phase of the URL being split
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_HOST,
    PH_PORT,
    PH_PATH,
    PH_TAIL,
    PH_FAIL_HOST,
    PH_FAIL_PORT
  } phase_e;

  // Operation presented to the step unit
  typedef enum logic {
    OP_BYTE,
    OP_FINISH
  } op_e;

  // Result roles
  localparam logic [1:0] ROLE_HOST    = 2'd0;
  localparam logic [1:0] ROLE_PATH    = 2'd1;
  localparam logic [1:0] ROLE_SUMMARY = 2'd2;

  // Summary status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY_HOST = 2'd1;
  localparam logic [1:0] ST_BAD_PORT   = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LOW_S = 8'h73;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [16:0] PORT_MAX = 17'd65535;
  localparam logic [16:0] PORT_SAT = 17'd65536;
  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;

  // Position of the scheme branch point ("http" then ':' or 's')
  localparam logic [2:0] PFX_BRANCH = 3'd4;
  localparam logic [3:0] PLAIN_PFX_LEN  = 4'd7;
  localparam logic [3:0] SECURE_PFX_LEN = 4'd8;

  localparam logic [7:0] PLAIN_PFX [8] = '{
    8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 8'h00
  };
  localparam logic [7:0] SECURE_PFX [8] = '{
    8'h68, 8'h74, 8'h74, 8'h70, 8'h73, 8'h3A, 8'h2F, 8'h2F
  };

  // Per-URL parse state handled by the step unit
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  host_len;
    logic [7:0]  path_len;
    logic [16:0] port_acc;
    logic        port_ovf;
  } url_state_t;

  localparam url_state_t URL_STATE_RST = '{
    phase:    PH_PREFIX,
    host_len: 8'd0,
    path_len: 8'd0,
    port_acc: 17'd0,
    port_ovf: 1'b0
  };

  // One result produced by the step unit
  typedef struct packed {
    logic        valid;
    logic [1:0]  role;
    logic [7:0]  data;
    logic [15:0] port;
    logic        secure;
    logic [1:0]  status;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic secure, input logic [2:0] idx);
    return secure ? SECURE_PFX[idx] : PLAIN_PFX[idx];
  endfunction

endpackage

// ----- rtl/uhps_if.sv -----
// ----------------------------------------------------------------------------
// URL host/port/path splitter - stream interfaces
// Valid/ready channels for URL bytes in and split results out.
// ----------------------------------------------------------------------------
interface uhps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       is_end;

  modport source (output valid, output url_byte, output is_end, input ready);
  modport sink (input valid, input url_byte, input is_end, output ready);
endinterface

interface uhps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic [7:0]  out_byte;
  logic [15:0] port_number;
  logic        secure_scheme;
  logic [1:0]  parse_status;
  logic        last_of_run;

  modport source (
    output valid, output byte_role, output out_byte, output port_number,
    output secure_scheme, output parse_status, output last_of_run, input ready
  );
  modport sink (
    input valid, input byte_role, input out_byte, input port_number,
    input secure_scheme, input parse_status, input last_of_run, output ready
  );
endinterface

// ----- rtl/uhps_step.sv -----
// ----------------------------------------------------------------------------
// URL host/port/path splitter - step unit
// Applies one URL byte, or one finish step, to the parse state and yields at
// most one result.
// ----------------------------------------------------------------------------
module uhps_step import uhps_pkg::*; #(
  parameter int unsigned HOST_LIMIT = 255,
  parameter int unsigned PATH_LIMIT = 255
) (
  input  op_e         op_i,
  input  logic [7:0]  data_i,
  input  url_state_t  state_i,
  input  logic        secure_i,
  input  logic [15:0] default_port_i,
  output url_state_t  state_o,
  output result_t     res_o,
  output logic        done_o
);

  localparam logic [7:0] HostLim = 8'(HOST_LIMIT);
  localparam logic [7:0] PathLim = 8'(PATH_LIMIT);

  logic        is_digit;
  logic        is_slash;
  logic        is_colon;
  logic [19:0] acc_next;
  logic        port_bad;

  assign is_digit = (data_i >= CH_ZERO) && (data_i <= CH_NINE);
  assign is_slash = (data_i == CH_SLASH);
  assign is_colon = (data_i == CH_COLON);
  // acc * 10 + digit, as (acc << 3) + (acc << 1) + digit
  assign acc_next = {state_i.port_acc, 3'b000} + 20'({state_i.port_acc, 1'b0})
                  + {16'd0, data_i[3:0]};
  assign port_bad = state_i.port_ovf || (state_i.port_acc == 17'd0);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    done_o  = 1'b0;
    unique case (op_i)
      OP_BYTE: begin
        unique case (state_i.phase)
          PH_HOST: begin
            if (is_slash || is_colon || (state_i.host_len >= HostLim)) begin
              if (state_i.host_len == 8'd0) begin
                state_o.phase = PH_FAIL_HOST;
              end else if (is_colon) begin
                state_o.port_acc = 17'd0;
                state_o.port_ovf = 1'b0;
                state_o.phase    = PH_PORT;
              end else if (is_slash) begin
                res_o.valid      = 1'b1;
                res_o.role       = ROLE_PATH;
                res_o.data       = CH_SLASH;
                state_o.path_len = 8'd1;
                state_o.phase    = PH_PATH;
              end else begin
                state_o.phase = PH_TAIL;
              end
            end else begin
              res_o.valid      = 1'b1;
              res_o.role       = ROLE_HOST;
              res_o.data       = data_i;
              state_o.host_len = state_i.host_len + 8'd1;
            end
          end
          PH_PORT: begin
            if (is_digit) begin
              if (acc_next > 20'(PORT_MAX)) begin
                state_o.port_acc = PORT_SAT;
                state_o.port_ovf = 1'b1;
              end else begin
                state_o.port_acc = acc_next[16:0];
              end
            end else if (port_bad) begin
              state_o.phase = PH_FAIL_PORT;
            end else if (is_slash) begin
              res_o.valid      = 1'b1;
              res_o.role       = ROLE_PATH;
              res_o.data       = CH_SLASH;
              state_o.path_len = 8'd1;
              state_o.phase    = PH_PATH;
            end else begin
              state_o.phase = PH_TAIL;
            end
          end
          PH_PATH: begin
            if (state_i.path_len < PathLim) begin
              res_o.valid      = 1'b1;
              res_o.role       = ROLE_PATH;
              res_o.data       = data_i;
              state_o.path_len = state_i.path_len + 8'd1;
            end
          end
          default: ;
        endcase
      end
      OP_FINISH: begin
        res_o.valid  = 1'b1;
        res_o.role   = ROLE_SUMMARY;
        res_o.secure = secure_i;
        if ((state_i.phase == PH_FAIL_HOST) ||
            ((state_i.phase == PH_HOST) && (state_i.host_len == 8'd0))) begin
          res_o.status = ST_EMPTY_HOST;
          state_o      = URL_STATE_RST;
          done_o       = 1'b1;
        end else if ((state_i.phase == PH_FAIL_PORT) ||
                     ((state_i.phase == PH_PORT) && port_bad)) begin
          res_o.status = ST_BAD_PORT;
          state_o      = URL_STATE_RST;
          done_o       = 1'b1;
        end else if (state_i.phase != PH_PATH) begin
          // No path seen: send the lone slash, summary follows next step
          res_o.role    = ROLE_PATH;
          res_o.data    = CH_SLASH;
          res_o.secure  = 1'b0;
          state_o.phase = PH_PATH;
        end else begin
          res_o.status = ST_OK;
          res_o.port   = (state_i.port_acc != 17'd0) ? state_i.port_acc[15:0]
                                                     : default_port_i;
          state_o      = URL_STATE_RST;
          done_o       = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/url_host_port_path_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// URL host/port/path splitter - top level
// Sequencing: an accepted byte has any held prefix bytes replayed through the
// step unit first; an ordinary byte is then applied, a terminator runs the
// finish steps. The held-back result is flushed last. A byte that extends a
// scheme prefix match yields no result. No new byte is taken before the flush,
// owing to the single shared step unit and the result hold/flush stage; output stalls delay it.
// Reset: asynchronous, active low; parse state cleared, default port 80.
// ----------------------------------------------------------------------------
module url_host_port_path_splitter_unit import uhps_pkg::*; #(
  parameter int unsigned HOST_LIMIT = 255,
  parameter int unsigned PATH_LIMIT = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  uhps_in_if.sink       in_i,
  uhps_out_if.source    out_o
);

  // Sequencer: accept, run the step unit over held prefix bytes and the
  // current byte, run the finish steps, then flush the held-back result.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN,
    S_FLUSH
  } seq_e;

  seq_e        seq_q, seq_d;
  url_state_t  ust_q, ust_d;
  logic [2:0]  pm_q, pm_d;          // prefix bytes matched so far
  logic        sec_q, sec_d;        // secure prefix branch
  logic [2:0]  rep_cnt_q, rep_cnt_d;
  logic [2:0]  rep_idx_q, rep_idx_d;
  logic        rep_sec_q, rep_sec_d;
  logic [7:0]  pend_data_q, pend_data_d;
  logic        pend_valid_q, pend_valid_d;
  logic        do_fin_q, do_fin_d;
  result_t     hold_q, hold_d;      // newest result, held until we know if it is last
  result_t     out_res_q, out_res_d;
  logic        out_valid_q, out_valid_d;
  logic        out_last_q, out_last_d;
  logic [15:0] dport_q, dport_d;

  logic        in_acc;
  logic        is_end;
  logic        out_free;
  logic        rep_active;
  logic        last_op;
  logic        step_apply;
  op_e         step_op;
  logic [7:0]  step_data;
  url_state_t  step_state;
  result_t     step_res;
  logic        step_done;
  logic        pfx_ok;
  logic        pfx_sec;
  logic [3:0]  pfx_next;

  assign in_i.ready = (seq_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_end     = in_i.is_end || (in_i.url_byte == 8'd0);
  assign out_free   = !out_valid_q || out_o.ready;
  assign rep_active = (rep_idx_q < rep_cnt_q);
  assign last_op    = rep_active ? ((({1'b0, rep_idx_q} + 4'd1) == {1'b0, rep_cnt_q})
                                    && !pend_valid_q)
                                 : 1'b1;

  assign step_op   = (seq_q == S_FIN) ? OP_FINISH : OP_BYTE;
  assign step_data = rep_active ? prefix_char(rep_sec_q, rep_idx_q) : pend_data_q;

  uhps_step #(
    .HOST_LIMIT (HOST_LIMIT),
    .PATH_LIMIT (PATH_LIMIT)
  ) u_step (
    .op_i           (step_op),
    .data_i         (step_data),
    .state_i        (ust_q),
    .secure_i       (sec_q),
    .default_port_i (dport_q),
    .state_o        (step_state),
    .res_o          (step_res),
    .done_o         (step_done)
  );

  // Scheme prefix compare: "http" then ':' (plain) or 's' (secure)
  always_comb begin
    if (pm_q == PFX_BRANCH) begin
      pfx_ok  = (in_i.url_byte == CH_COLON) || (in_i.url_byte == CH_LOW_S);
      pfx_sec = (in_i.url_byte == CH_LOW_S);
    end else begin
      pfx_ok  = (in_i.url_byte == prefix_char(sec_q, pm_q));
      pfx_sec = sec_q;
    end
    pfx_next = {1'b0, pm_q} + 4'd1;
  end

  always_comb begin
    seq_d        = seq_q;
    ust_d        = ust_q;
    pm_d         = pm_q;
    sec_d        = sec_q;
    rep_cnt_d    = rep_cnt_q;
    rep_idx_d    = rep_idx_q;
    rep_sec_d    = rep_sec_q;
    pend_data_d  = pend_data_q;
    pend_valid_d = pend_valid_q;
    do_fin_d     = do_fin_q;
    hold_d       = hold_q;
    out_res_d    = out_res_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_last_d   = out_last_q;
    dport_d      = cfg_we_i ? cfg_wdata_i : dport_q;
    step_apply   = 1'b0;

    unique case (seq_q)
      S_IDLE: begin
        if (in_acc) begin
          rep_idx_d   = 3'd0;
          rep_cnt_d   = 3'd0;
          pend_data_d = in_i.url_byte;
          if (is_end) begin
            pend_valid_d = 1'b0;
            do_fin_d     = 1'b1;
            if (ust_q.phase == PH_PREFIX) begin
              // Terminator mid-prefix: replay the held bytes as host text
              rep_cnt_d   = pm_q;
              rep_sec_d   = sec_q;
              pm_d        = 3'd0;
              sec_d       = 1'b0;
              ust_d.phase = PH_HOST;
              seq_d       = (pm_q != 3'd0) ? S_RUN : S_FIN;
            end else begin
              seq_d = S_FIN;
            end
          end else if (ust_q.phase == PH_PREFIX) begin
            if (pfx_ok) begin
              // Advance the match; no result for this transaction
              sec_d = pfx_sec;
              if (pfx_next == (pfx_sec ? SECURE_PFX_LEN : PLAIN_PFX_LEN)) begin
                pm_d        = 3'd0;
                ust_d.phase = PH_HOST;
              end else begin
                pm_d = pfx_next[2:0];
              end
            end else begin
              // Mismatch: replay held bytes, then the failing byte
              rep_cnt_d    = pm_q;
              rep_sec_d    = sec_q;
              pm_d         = 3'd0;
              sec_d        = 1'b0;
              ust_d.phase  = PH_HOST;
              pend_valid_d = 1'b1;
              do_fin_d     = 1'b0;
              seq_d        = S_RUN;
            end
          end else begin
            pend_valid_d = 1'b1;
            do_fin_d     = 1'b0;
            seq_d        = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (out_free) begin
          step_apply = 1'b1;
          if (rep_active) begin
            rep_idx_d = rep_idx_q + 3'd1;
          end else begin
            pend_valid_d = 1'b0;
          end
          if (last_op) begin
            seq_d = do_fin_q ? S_FIN : S_FLUSH;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          step_apply = 1'b1;
          if (step_done) begin
            pm_d  = 3'd0;
            sec_d = 1'b0;
            seq_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (hold_q.valid) begin
            out_res_d    = hold_q;
            out_last_d   = 1'b1;
            out_valid_d  = 1'b1;
            hold_d.valid = 1'b0;
          end
          seq_d = S_IDLE;
        end
      end
      default: seq_d = S_IDLE;
    endcase

    // Commit the step unit; a new result pushes the held one out as not last
    if (step_apply) begin
      ust_d = step_state;
      if (step_res.valid) begin
        if (hold_q.valid) begin
          out_res_d   = hold_q;
          out_last_d  = 1'b0;
          out_valid_d = 1'b1;
        end
        hold_d = step_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= S_IDLE;
      ust_q        <= URL_STATE_RST;
      pm_q         <= 3'd0;
      sec_q        <= 1'b0;
      rep_cnt_q    <= 3'd0;
      rep_idx_q    <= 3'd0;
      rep_sec_q    <= 1'b0;
      pend_data_q  <= 8'd0;
      pend_valid_q <= 1'b0;
      do_fin_q     <= 1'b0;
      hold_q       <= '0;
      out_res_q    <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      dport_q      <= DEFAULT_PORT_RST;
    end else begin
      seq_q        <= seq_d;
      ust_q        <= ust_d;
      pm_q         <= pm_d;
      sec_q        <= sec_d;
      rep_cnt_q    <= rep_cnt_d;
      rep_idx_q    <= rep_idx_d;
      rep_sec_q    <= rep_sec_d;
      pend_data_q  <= pend_data_d;
      pend_valid_q <= pend_valid_d;
      do_fin_q     <= do_fin_d;
      hold_q       <= hold_d;
      out_res_q    <= out_res_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      dport_q      <= dport_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.byte_role     = out_res_q.role;
  assign out_o.out_byte      = out_res_q.data;
  assign out_o.port_number   = out_res_q.port;
  assign out_o.secure_scheme = out_res_q.secure;
  assign out_o.parse_status  = out_res_q.status;
  assign out_o.last_of_run   = out_last_q;

  // The held result must be flushed before the next transaction is taken
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == S_IDLE) |-> !hold_q.valid)
    else $error("held result left behind on return to idle");

  // A summary always closes its transaction's results
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.role == ROLE_SUMMARY)) |-> out_last_q)
    else $error("summary result not marked last");

  // Error summaries carry no port
  a_error_no_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.role == ROLE_SUMMARY) && (out_res_q.status != ST_OK))
      |-> (out_res_q.port == 16'd0))
    else $error("port reported with an error status");

  // After the finish steps complete, parsing restarts at the scheme prefix
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((seq_q == S_FIN) && out_free && step_done) |=>
      ((ust_q.phase == PH_PREFIX) && (pm_q == 3'd0) && !sec_q))
    else $error("parse state not cleared after summary");

endmodule
